### rtl/device_address_table_core_assert.svh
// Assertion macros for the device address table checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef DEVICE_ADDRESS_TABLE_CORE_ASSERT_SVH
`define DEVICE_ADDRESS_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define DAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define DAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dat_pkg.sv
// Shared types and constants for the device address table.
// No dependencies; imported by every module of the block.
package dat_pkg;

  localparam int DAT_TABLE_DEPTH = 16;
  localparam int DAT_ADDR_W      = 16;
  localparam int DAT_SER_W       = 32;
  localparam int DAT_IDX_W       = 8;
  localparam int DAT_CNT_W       = 8;

  typedef enum logic [2:0] {
    OP_ALLOCATE    = 3'd0,
    OP_ADD         = 3'd1,
    OP_REMOVE      = 3'd2,
    OP_FIND_ADDR   = 3'd3,
    OP_FIND_SERIAL = 3'd4,
    OP_READ_INDEX  = 3'd5
  } dat_op_t;

  typedef enum logic {
    ST_OK    = 1'b0,
    ST_ERROR = 1'b1
  } dat_status_t;

  // Outcome of comparing one slot against the search keys.
  typedef struct packed {
    logic addr_hit;
    logic ser_hit;
    logic empty;
  } dat_cmp_t;

endpackage

### rtl/dat_slot_cmp.sv
// Shared slot comparator of the device address table walk.
// Depends on dat_pkg.
module dat_slot_cmp
  import dat_pkg::*;
(
  input  logic [DAT_ADDR_W-1:0] slot_addr,
  input  logic [DAT_SER_W-1:0]  slot_serial,
  input  logic [DAT_ADDR_W-1:0] key_addr,
  input  logic [DAT_SER_W-1:0]  key_serial,
  output dat_cmp_t              cmp
);

  assign cmp.addr_hit = (slot_addr == key_addr);
  assign cmp.ser_hit  = (slot_serial == key_serial);
  assign cmp.empty    = (slot_addr == '0);

endmodule

### rtl/device_address_table_core.sv
// Device address table: top level with sequencer, slot memory and counters.
// Depends on dat_pkg and dat_slot_cmp.
//
// An item is taken when start is high and busy is low; for a walk or a read,
// busy then stays high until the item is finished, and the answer appears on
// the out_ ports for exactly one cycle with out_valid high. The receiver
// cannot stall, so sample out_ fields in that cycle; out_device_count also
// stays valid afterwards. Allocate, add, remove, find by address and find by
// serial walk the table one slot per cycle through a single comparator fed
// from the registered read port of the slot memory; a hit ends the walk
// early. Read by index passes through S_RD_WAIT, where the read data is
// registered, and then S_RD_DONE. Items rejected up front (address zero,
// index out of range, unknown operation) answer in the cycle after accept
// and never raise busy. The table is empty after reset with no clearing
// pass: a valid bit per slot marks written entries.
module device_address_table_core
  import dat_pkg::*;
#(
  parameter int TABLE_DEPTH = DAT_TABLE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_operation,
  input  logic [DAT_ADDR_W-1:0] in_address,
  input  logic [DAT_SER_W-1:0]  in_serial,
  input  logic [DAT_IDX_W-1:0]  in_index,
  output logic                  out_valid,
  output logic                  out_status,
  output logic [DAT_ADDR_W-1:0] out_result_address,
  output logic [DAT_SER_W-1:0]  out_result_serial,
  output logic [DAT_IDX_W-1:0]  out_result_index,
  output logic [DAT_CNT_W-1:0]  out_device_count
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RD_WAIT,
    S_RD_DONE
  } state_t;

  state_t                  state_r;
  dat_op_t                 op_r;
  logic [DAT_ADDR_W-1:0]   key_addr_r;
  logic [DAT_SER_W-1:0]    key_ser_r;
  logic [IDX_W-1:0]        rd_addr_r;
  logic                    issue_vld_r;
  logic                    cmp_vld_r;
  logic [IDX_W-1:0]        cmp_idx_r;
  logic                    have_empty_r;
  logic [IDX_W-1:0]        empty_idx_r;
  logic                    tgt_empty_r;
  logic [CNT_W-1:0]        count_r;
  logic [TABLE_DEPTH-1:0]  valid_r;
  logic                    slot_v_r;

  logic                    out_valid_r;
  logic                    out_status_r;
  logic [DAT_ADDR_W-1:0]   out_addr_r;
  logic [DAT_SER_W-1:0]    out_ser_r;
  logic [DAT_IDX_W-1:0]    out_idx_r;

  // Slot memory with registered read data.
  logic [DAT_ADDR_W-1:0]   mem_addr [TABLE_DEPTH];
  logic [DAT_SER_W-1:0]    mem_ser  [TABLE_DEPTH];
  logic [DAT_ADDR_W-1:0]   rd_a_r;
  logic [DAT_SER_W-1:0]    rd_s_r;

  // Walk decision.
  logic                    fin;
  logic                    fin_ok;
  logic [IDX_W-1:0]        fin_idx;
  logic [DAT_ADDR_W-1:0]   fin_addr;
  logic [DAT_SER_W-1:0]    fin_ser;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_idx;
  logic                    set_valid;
  logic                    clr_valid;
  logic                    cnt_inc;
  logic                    cnt_dec;

  logic [DAT_ADDR_W-1:0]   slot_addr;
  logic [DAT_SER_W-1:0]    slot_ser;
  dat_cmp_t                cmp;
  logic                    last;
  logic [DAT_ADDR_W-1:0]   key_addr_m1;
  logic                    tgt_in_range;
  logic                    at_tgt;
  logic                    tgt_empty_now;
  logic                    empty_now;
  logic [IDX_W-1:0]        empty_idx_now;

  logic                    accept;
  dat_op_t                 in_op;
  logic                    early_err;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign in_op  = dat_op_t'(in_operation);

  // Reject items that need no walk.
  always_comb begin
    case (in_op)
      OP_ALLOCATE, OP_FIND_SERIAL: early_err = 1'b0;
      OP_ADD, OP_REMOVE, OP_FIND_ADDR: early_err = (in_address == '0);
      OP_READ_INDEX: early_err = (in_index >= DAT_IDX_W'(TABLE_DEPTH));
      default: early_err = 1'b1;
    endcase
  end

  // An unwritten slot reads as empty.
  assign slot_addr = slot_v_r ? rd_a_r : '0;
  assign slot_ser  = slot_v_r ? rd_s_r : '0;

  dat_slot_cmp u_cmp (
    .slot_addr  (slot_addr),
    .slot_serial(slot_ser),
    .key_addr   (key_addr_r),
    .key_serial (key_ser_r),
    .cmp        (cmp)
  );

  assign last          = (cmp_idx_r == LAST_IDX);
  assign key_addr_m1   = key_addr_r - DAT_ADDR_W'(1);
  assign tgt_in_range  = (key_addr_m1 < DAT_ADDR_W'(TABLE_DEPTH));
  assign at_tgt        = (DAT_ADDR_W'(cmp_idx_r) == key_addr_m1);
  assign tgt_empty_now = tgt_empty_r || (at_tgt && cmp.empty);
  assign empty_now     = have_empty_r || cmp.empty;
  assign empty_idx_now = have_empty_r ? empty_idx_r : cmp_idx_r;

  always_comb begin
    fin       = 1'b0;
    fin_ok    = 1'b0;
    fin_idx   = cmp_idx_r;
    fin_addr  = slot_addr;
    fin_ser   = slot_ser;
    wr_en     = 1'b0;
    wr_idx    = cmp_idx_r;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    if (state_r == S_RD_DONE) begin
      fin     = 1'b1;
      fin_ok  = 1'b1;
      fin_idx = rd_addr_r;
    end else if (state_r == S_WALK && cmp_vld_r) begin
      case (op_r)
        OP_ALLOCATE: begin
          // Serial match wins, else the first empty slot seen.
          if (cmp.ser_hit) begin
            fin      = 1'b1;
            fin_ok   = 1'b1;
            fin_addr = DAT_ADDR_W'(cmp_idx_r) + DAT_ADDR_W'(1);
          end else if (last) begin
            fin      = 1'b1;
            fin_ok   = empty_now;
            fin_idx  = empty_idx_now;
            fin_addr = DAT_ADDR_W'(empty_idx_now) + DAT_ADDR_W'(1);
            fin_ser  = '0;
          end
        end
        OP_ADD: begin
          if (cmp.addr_hit) begin
            fin      = 1'b1;
            fin_ok   = 1'b1;
            fin_addr = key_addr_r;
            fin_ser  = key_ser_r;
            wr_en    = 1'b1;
          end else if (last) begin
            fin = 1'b1;
            if (tgt_in_range && tgt_empty_now) begin
              fin_ok    = 1'b1;
              fin_idx   = key_addr_m1[IDX_W-1:0];
              fin_addr  = key_addr_r;
              fin_ser   = key_ser_r;
              wr_en     = 1'b1;
              wr_idx    = key_addr_m1[IDX_W-1:0];
              set_valid = 1'b1;
              cnt_inc   = 1'b1;
            end
          end
        end
        OP_REMOVE: begin
          if (cmp.addr_hit) begin
            fin       = 1'b1;
            fin_ok    = 1'b1;
            clr_valid = 1'b1;
            cnt_dec   = 1'b1;
          end else if (last) begin
            fin = 1'b1;
          end
        end
        OP_FIND_ADDR: begin
          if (cmp.addr_hit) begin
            fin    = 1'b1;
            fin_ok = 1'b1;
          end else if (last) begin
            fin = 1'b1;
          end
        end
        OP_FIND_SERIAL: begin
          if (cmp.ser_hit && key_ser_r != '0) begin
            fin    = 1'b1;
            fin_ok = 1'b1;
          end else if (last) begin
            fin = 1'b1;
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_addr[wr_idx] <= key_addr_r;
      mem_ser[wr_idx]  <= key_ser_r;
    end
    rd_a_r <= mem_addr[rd_addr_r];
    rd_s_r <= mem_ser[rd_addr_r];
  end

  // Sequencer, counters and result register.
  always_ff @(posedge clk) begin
    // Payload registers, no reset needed.
    slot_v_r  <= valid_r[rd_addr_r];
    cmp_idx_r <= rd_addr_r;
    if (accept) begin
      op_r       <= in_op;
      key_addr_r <= in_address;
      key_ser_r  <= in_serial;
    end
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issue_vld_r  <= 1'b0;
      cmp_vld_r    <= 1'b0;
      have_empty_r <= 1'b0;
      empty_idx_r  <= '0;
      tgt_empty_r  <= 1'b0;
      rd_addr_r    <= '0;
      count_r      <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_OK;
      out_addr_r   <= '0;
      out_ser_r    <= '0;
      out_idx_r    <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            have_empty_r <= 1'b0;
            tgt_empty_r  <= 1'b0;
            if (early_err) begin
              // Answer at once with an error.
              out_valid_r  <= 1'b1;
              out_status_r <= ST_ERROR;
              out_addr_r   <= '0;
              out_ser_r    <= '0;
              out_idx_r    <= '0;
            end else if (in_op == OP_READ_INDEX) begin
              rd_addr_r <= in_index[IDX_W-1:0];
              state_r   <= S_RD_WAIT;
            end else begin
              rd_addr_r   <= '0;
              issue_vld_r <= 1'b1;
              state_r     <= S_WALK;
            end
          end
        end
        S_WALK: begin
          // Advance the read address one slot per cycle.
          if (issue_vld_r) begin
            if (rd_addr_r != LAST_IDX) begin
              rd_addr_r <= rd_addr_r + IDX_W'(1);
            end
            issue_vld_r <= (rd_addr_r != LAST_IDX);
          end
          cmp_vld_r <= issue_vld_r;
          if (cmp_vld_r) begin
            if (cmp.empty && !have_empty_r) begin
              have_empty_r <= 1'b1;
              empty_idx_r  <= cmp_idx_r;
            end
            if (at_tgt && cmp.empty) begin
              tgt_empty_r <= 1'b1;
            end
          end
        end
        S_RD_WAIT: begin
          state_r <= S_RD_DONE;
        end
        S_RD_DONE: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (fin) begin
        state_r      <= S_IDLE;
        issue_vld_r  <= 1'b0;
        cmp_vld_r    <= 1'b0;
        out_valid_r  <= 1'b1;
        out_status_r <= fin_ok ? ST_OK : ST_ERROR;
        out_addr_r   <= fin_ok ? fin_addr : '0;
        out_ser_r    <= fin_ok ? fin_ser : '0;
        out_idx_r    <= fin_ok ? DAT_IDX_W'(fin_idx) : '0;
      end
      if (set_valid) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (clr_valid) begin
        valid_r[cmp_idx_r] <= 1'b0;
      end
      if (cnt_inc) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cnt_dec) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;
  assign out_result_serial  = out_ser_r;
  assign out_result_index   = out_idx_r;
  assign out_device_count   = DAT_CNT_W'(count_r);

endmodule

### rtl/dat_checker.sv
// Port-level checker for the device address table, bound to the top level.
// Depends on dat_pkg and device_address_table_core_assert.svh.
`include "device_address_table_core_assert.svh"

module dat_checker
  import dat_pkg::*;
#(
  parameter int TABLE_DEPTH = DAT_TABLE_DEPTH
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic                  out_status,
  input logic [DAT_ADDR_W-1:0] out_result_address,
  input logic [DAT_SER_W-1:0]  out_result_serial,
  input logic [DAT_IDX_W-1:0]  out_result_index,
  input logic [DAT_CNT_W-1:0]  out_device_count
);

  // An accepted item either answers next cycle or holds busy.
  `DAT_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid, "item lost after accept")

  // The result strobe only shows once the block is free again.
  `DAT_ASSERT_NOW(a_result_not_busy, out_valid, !busy, "result shown while busy")

  // Error answers carry zeroed slot fields.
  `DAT_ASSERT_NOW(a_error_zero, out_valid && out_status, out_result_address == '0 && out_result_serial == '0 && out_result_index == '0, "error result carries slot data")

  // Successful answers point inside the table.
  `DAT_ASSERT_NOW(a_index_range, out_valid && !out_status, out_result_index < DAT_IDX_W'(TABLE_DEPTH), "result index beyond table")

  // Device count moves only together with a result.
  `DAT_ASSERT_NOW(a_count_moves, $past(rst_n) && out_device_count != $past(out_device_count), out_valid, "device count changed without a result")

endmodule

bind device_address_table_core dat_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_dat_checker (.*);
